### src/b2a_pkg.sv
`timescale 1ns / 1ps

package b2a_pkg;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // format selector codes
  localparam logic OP_DEC = 1'b0;
  localparam logic OP_HEX = 1'b1;

  // digit counts and final digit positions
  localparam logic [2:0] DEC_DIGITS    = 3'd5;
  localparam logic [2:0] HEX_DIGITS    = 3'd4;
  localparam logic [2:0] HEX_SHORT     = 3'd2;
  localparam logic [2:0] DEC_LAST_POS  = 3'd4;
  localparam logic [2:0] HEX_LAST_POS  = 3'd3;
  localparam logic [15:0] HEX_BYTE_MAX = 16'h00FF;

  // classified item held in the queue
  typedef struct packed {
    logic [15:0] value;
    logic        opcode;
    logic [2:0]  char_count;
  } item_t;

  // ascii code of one digit, "0123456789ABCDEF"
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] code;
    if (d < 4'd10) begin
      code = 8'h30 + {4'h0, d};
    end else begin
      code = 8'h37 + {4'h0, d};
    end
    return code;
  endfunction

  // k times the decimal weight of digit position pos (10000 down to 1)
  function automatic logic [16:0] dec_multiple(input logic [2:0] pos, input logic [3:0] k);
    logic [16:0] w;
    case (pos)
      3'd0: w = 17'd10000;
      3'd1: w = 17'd1000;
      3'd2: w = 17'd100;
      3'd3: w = 17'd10;
      default: w = 17'd1;
    endcase
    return w * {13'd0, k};
  endfunction

endpackage

### src/b2a_front.sv
`timescale 1ns / 1ps

module b2a_front (
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [15:0]    in_value,
  input  logic           in_opcode,
  output logic           push_valid,
  input  logic           push_ready,
  output b2a_pkg::item_t push_item
);
  import b2a_pkg::*;

  logic [2:0] count;

  // character count from the value's magnitude and the format
  always_comb begin
    if (in_opcode == OP_HEX) begin
      count = (in_value > HEX_BYTE_MAX) ? HEX_DIGITS : HEX_SHORT;
    end else if (in_value >= 16'd10000) begin
      count = 3'd5;
    end else if (in_value >= 16'd1000) begin
      count = 3'd4;
    end else if (in_value >= 16'd100) begin
      count = 3'd3;
    end else if (in_value >= 16'd10) begin
      count = 3'd2;
    end else begin
      count = 3'd1;
    end
  end

  // hand the classified item to the queue
  assign push_valid           = in_tvalid;
  assign in_tready            = push_ready;
  assign push_item.value      = in_value;
  assign push_item.opcode     = in_opcode;
  assign push_item.char_count = count;

endmodule

### src/b2a_queue.sv
`timescale 1ns / 1ps

module b2a_queue #(
  parameter int DEPTH = b2a_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  b2a_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output b2a_pkg::item_t pop_item
);
  import b2a_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  item_t            mem_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CntW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### src/b2a_back.sv
`timescale 1ns / 1ps

module b2a_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  b2a_pkg::item_t pop_item,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_char_code,
  output logic [2:0]     out_char_count,
  output logic           out_last
);
  import b2a_pkg::*;

  // active item being spelled out
  logic        act_r, act_nxt;
  logic [15:0] val_r, val_nxt;
  logic        hex_r, hex_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [2:0]  pos_r, pos_nxt;

  // output register
  logic        ovalid_r, ovalid_nxt;
  logic [7:0]  ochar_r;
  logic [2:0]  ocount_r;
  logic        olast_r;

  logic [3:0]  dec_digit;
  logic [16:0] dec_rem;
  logic [3:0]  nib_shift;
  logic [3:0]  hex_digit;
  logic [7:0]  cur_char;
  logic        cur_last;
  logic        advance;
  logic        load;

  // decimal digit at the current position by comparing against its multiples
  always_comb begin
    dec_digit = '0;
    for (int k = 1; k < 10; k++) begin
      if ({1'b0, val_r} >= dec_multiple(pos_r, 4'(k))) begin
        dec_digit = 4'(k);
      end
    end
    dec_rem = {1'b0, val_r} - dec_multiple(pos_r, dec_digit);
  end

  // hex nibble at the current position, most significant first
  assign nib_shift = 4'd12 - {pos_r[1:0], 2'b00};
  assign hex_digit = 4'(val_r >> nib_shift);

  assign cur_char = digit_char((hex_r == OP_HEX) ? hex_digit : dec_digit);
  assign cur_last = (hex_r == OP_HEX) ? (pos_r == HEX_LAST_POS) : (pos_r == DEC_LAST_POS);

  // one character per cycle into the output register while the output is not stalled
  assign advance   = act_r && (!ovalid_r || out_tready);
  assign load      = pop_valid && (!act_r || (advance && cur_last));
  assign pop_ready = !act_r || (advance && cur_last);

  always_comb begin
    act_nxt    = act_r;
    val_nxt    = val_r;
    hex_nxt    = hex_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    ovalid_nxt = ovalid_r;
    if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
    if (advance) begin
      ovalid_nxt = 1'b1;
      pos_nxt    = pos_r + 1'b1;
      if (hex_r == OP_DEC) begin
        val_nxt = dec_rem[15:0];
      end
      if (cur_last) begin
        act_nxt = 1'b0;
      end
    end
    if (load) begin
      act_nxt = 1'b1;
      val_nxt = pop_item.value;
      hex_nxt = pop_item.opcode;
      cnt_nxt = pop_item.char_count;
      pos_nxt = (pop_item.opcode == OP_HEX) ? HEX_DIGITS - pop_item.char_count
                                            : DEC_DIGITS - pop_item.char_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      act_r    <= act_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    hex_r <= hex_nxt;
    cnt_r <= cnt_nxt;
    pos_r <= pos_nxt;
    if (advance) begin
      ochar_r  <= cur_char;
      ocount_r <= cnt_r;
      olast_r  <= cur_last;
    end
  end

  assign out_tvalid     = ovalid_r;
  assign out_char_code  = ochar_r;
  assign out_char_count = ocount_r;
  assign out_last       = olast_r;

endmodule

### src/binary_to_ascii_dec_hex.sv
`timescale 1ns / 1ps
// Converts a 16-bit unsigned value to ASCII text, one character per output item,
// most significant first. tuser selects the format: 0 gives decimal with leading
// zeros dropped (at least one digit), 1 gives uppercase hex, four digits above
// 0xFF and two otherwise. Every character carries the total character count and
// tlast marks the final one. A value has 1 to 5 characters for decimal and 2 or
// 4 for hex. The digit sequencer in the back end produces exactly one character
// per cycle while the output does not stall; with the output ready, the next
// value's first character follows the previous value's last one in the next
// cycle. Up to QUEUE_DEPTH classified values wait in a queue between the input
// and the sequencer; during output stalls the input accepts until the queue fills.
module binary_to_ascii_dec_hex #(
  parameter int QUEUE_DEPTH = b2a_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] value
  input  logic        in_tuser,   // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] char_code, [10:8] char_count, [15:11] zero
  output logic        out_tlast
);
  import b2a_pkg::*;

  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop_ready;
  item_t pop_item;
  logic [7:0] char_code;
  logic [2:0] char_count;

  b2a_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_value   (in_tdata),
    .in_opcode  (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  b2a_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  b2a_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_item       (pop_item),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_char_code  (char_code),
    .out_char_count (char_count),
    .out_last       (out_tlast)
  );

  // pack the result fields
  assign out_tdata = {5'd0, char_count, char_code};

endmodule

### src/b2a_checker.sv
`timescale 1ns / 1ps

module b2a_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // character count stays within one to five
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[10:8] != 3'd0) && (out_tdata[10:8] != 3'd6) &&
                   (out_tdata[10:8] != 3'd7))
    else $error("character count out of range");

  // only digits and uppercase hex letters leave, padding bits zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:11] == 5'd0) &&
                   ((out_tdata[7:0] >= 8'h30 && out_tdata[7:0] <= 8'h39) ||
                    (out_tdata[7:0] >= 8'h41 && out_tdata[7:0] <= 8'h46)))
    else $error("bad character code");

  // a single-character value is always its own last character
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[10:8] == 3'd1) |-> out_tlast)
    else $error("one-character text without last flag");

endmodule

bind binary_to_ascii_dec_hex b2a_checker u_b2a_checker (.*);

### tb/sv/binary_to_ascii_dec_hex_tb.sv
`timescale 1ns / 1ps

module binary_to_ascii_dec_hex_tb;

  import b2a_pkg::*;

  localparam int RANDOM_ITEMS = 200;
  localparam int CALM_ITEMS   = 30;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 80;
  localparam int HOLD_AFTER   = 30;
  localparam int TAIL_CYCLES  = 20;
  localparam logic [127:0] GLYPHS = "0123456789ABCDEF";

  // one number to convert and its format
  typedef struct {
    logic [15:0] value;
    logic        opcode;
  } number_t;

  // one expected character of the text
  typedef struct {
    logic [7:0] code;
    logic [2:0] count;
    logic       last;
  } char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] value
  logic        in_tuser = 1'b0; // [0] opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [7:0] char_code, [10:8] char_count, [15:11] zero
  logic        out_tlast;

  number_t pending_numbers[$];
  char_t   expected_chars[$];
  int      total_items = 0;
  int      items_accepted = 0;
  int      chars_seen = 0;
  int      fail_count = 0;
  int      send_gap = 0;
  int      ready_gap = 0;
  int      hold_left = 0;
  bit      hold_done = 1'b0;
  int      idle_cycles = 0;
  logic    calm;

  binary_to_ascii_dec_hex DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // no idling near the end of the run
  assign calm = (items_accepted + CALM_ITEMS >= total_items);

  // ascii code of a digit 0..15
  function automatic logic [7:0] glyph(input logic [3:0] d);
    return GLYPHS[(15 - d) * 8 +: 8];
  endfunction

  // expected characters of one number, most significant first
  function automatic void predict_text(input number_t num);
    int     weights[5] = '{10000, 1000, 100, 10, 1};
    int     digits[5];
    logic [7:0] text[5];
    int     n;
    int     rest;
    int     lead;
    char_t  c;
    n = 0;
    rest = int'(num.value);
    if (num.opcode == OP_HEX) begin
      if (num.value > 16'h00FF) begin
        text[n] = glyph(num.value[15:12]);
        n = n + 1;
        text[n] = glyph(num.value[11:8]);
        n = n + 1;
      end
      text[n] = glyph(num.value[7:4]);
      n = n + 1;
      text[n] = glyph(num.value[3:0]);
      n = n + 1;
    end else begin
      lead = 4;
      for (int i = 4; i >= 0; i--) begin
        digits[i] = 0;
      end
      for (int i = 0; i < 5; i++) begin
        digits[i] = rest / weights[i];
        rest = rest % weights[i];
      end
      // first nonzero digit, the units digit always stays
      for (int i = 3; i >= 0; i--) begin
        if (digits[i] != 0) lead = i;
      end
      for (int i = lead; i < 5; i++) begin
        text[n] = glyph(4'(digits[i]));
        n = n + 1;
      end
    end
    for (int k = 0; k < n; k++) begin
      c.code = text[k];
      c.count = n[2:0];
      c.last = (k == n - 1);
      expected_chars.push_back(c);
    end
  endfunction

  task automatic add_number(input logic [15:0] value, input logic opcode);
    number_t num;
    num.value = value;
    num.opcode = opcode;
    pending_numbers.push_back(num);
  endtask

  // sender: offers pending numbers, predicts text on each accepted item
  always @(posedge clk) begin
    number_t num;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        num.value = in_tdata;
        num.opcode = in_tuser;
        predict_text(num);
        items_accepted <= items_accepted + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_numbers.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 6) == 0) begin
          send_gap = $urandom_range(1, 4) - 1;
          in_tvalid <= 1'b0;
        end else begin
          num = pending_numbers.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= num.value;
          in_tuser <= num.opcode;
        end
      end
    end
  end

  // receiver ready: random stalls and one long hold-off
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && chars_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else if (ready_gap > 0) begin
        ready_gap--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        ready_gap = $urandom_range(1, 4) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // checker: each character against the oldest expectation
  always @(posedge clk) begin
    char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      chars_seen <= chars_seen + 1;
      if (expected_chars.size() == 0) begin
        $error("unexpected character %h", out_tdata[7:0]);
        fail_count++;
      end else begin
        want = expected_chars.pop_front();
        if (out_tdata[7:0] !== want.code) begin
          $error("char_code expected %h got %h", want.code, out_tdata[7:0]);
          fail_count++;
        end
        if (out_tdata[10:8] !== want.count) begin
          $error("char_count expected %0d got %0d", want.count, out_tdata[10:8]);
          fail_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last expected %b got %b", want.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[binary_to_ascii_dec_hex] ERROR");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [15:0] v;
    // zero, extremes and the digit-count boundaries
    add_number(16'd0, OP_DEC);
    add_number(16'd0, OP_HEX);
    add_number(16'hFFFF, OP_DEC);
    add_number(16'hFFFF, OP_HEX);
    add_number(16'd9, OP_DEC);
    add_number(16'd10, OP_DEC);
    add_number(16'd99, OP_DEC);
    add_number(16'd100, OP_DEC);
    add_number(16'd999, OP_DEC);
    add_number(16'd1000, OP_DEC);
    add_number(16'd9999, OP_DEC);
    add_number(16'd10000, OP_DEC);
    add_number(16'd10009, OP_DEC);
    add_number(16'h00FF, OP_HEX);
    add_number(16'h0100, OP_HEX);
    add_number(16'h0005, OP_HEX);
    add_number(16'hABCD, OP_HEX);
    add_number(16'h5A5A, OP_HEX);
    add_number(16'hA5A5, OP_DEC);
    add_number(16'h00FF, OP_DEC);
    add_number(16'h8000, OP_DEC);
    add_number(16'd1, OP_HEX);
    // random numbers, weighted toward the boundaries
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(0, 3))
        0: v = 16'($urandom_range(0, 20));
        1: v = 16'($urandom_range(240, 300));
        2: v = 16'($urandom_range(9990, 10010));
        default: v = 16'($urandom);
      endcase
      add_number(v, 1'($urandom_range(0, 1)));
    end
    total_items = pending_numbers.size();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (items_accepted == total_items);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[binary_to_ascii_dec_hex] OK");
    end else begin
      $display("[binary_to_ascii_dec_hex] ERROR");
    end
    $finish;
  end

endmodule

### binary_to_ascii_dec_hex.f
src/b2a_pkg.sv
src/b2a_front.sv
src/b2a_queue.sv
src/b2a_back.sv
src/binary_to_ascii_dec_hex.sv
src/b2a_checker.sv
tb/sv/binary_to_ascii_dec_hex_tb.sv
